### rtl/core/scancode_set1_to_ascii_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scancode set 1 decoder core
// Clocked on clk_i, disabled while rst_ni is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_TO_ASCII_CORE_ASSERT_SVH
`define SCANCODE_SET1_TO_ASCII_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SC2A_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sc2a assertion failed");
// expression must never be true outside reset
`define SC2A_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("sc2a forbidden condition seen");
`else
`define SC2A_ASSERT(label, prop)
`define SC2A_ASSERT_NEVER(label, expr)
`endif

`endif

### rtl/core/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, codes and key tables shared by the scancode set 1 decoder.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam int unsigned SCAN_W     = 8;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned KEY_IDX_W  = 6;
  localparam int unsigned KEYMAP_LEN = 58;

  localparam logic [CODE_W-1:0] ARROW_UP_RST   = 8'd128;
  localparam logic [CODE_W-1:0] ARROW_DOWN_RST = 8'd129;

  // scancodes with a fixed meaning
  localparam logic [SCAN_W-1:0] SC_EXT_PREFIX = 8'hE0;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_MK  = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_MK  = 8'h36;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [SCAN_W-1:0] SC_CTRL_MK    = 8'h1D;
  localparam logic [SCAN_W-1:0] SC_CTRL_BRK   = 8'h9D;
  localparam logic [SCAN_W-1:0] SC_PGUP       = 8'h49;
  localparam logic [SCAN_W-1:0] SC_PGDN       = 8'h51;
  localparam logic [SCAN_W-1:0] SC_UP         = 8'h48;
  localparam logic [SCAN_W-1:0] SC_DOWN       = 8'h50;

  localparam logic [CODE_W-1:0] CTRL_MASK = 8'h1F;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 3'd0,
    KIND_CHAR  = 3'd1,
    KIND_UP    = 3'd2,
    KIND_DOWN  = 3'd3,
    KIND_PGUP  = 3'd4,
    KIND_PGDN  = 3'd5
  } result_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARROW_UP   = 1'b0,
    CFG_ARROW_DOWN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic ext;
  } flags_t;

  typedef struct packed {
    result_kind_e       kind;
    logic [CODE_W-1:0]  code;
  } result_t;

  // US layout, padded to 64 entries with zeros past the last key
  localparam logic [CODE_W-1:0] PLAIN_MAP [2**KEY_IDX_W] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [CODE_W-1:0] SHIFT_MAP [2**KEY_IDX_W] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

### rtl/core/sc2a_if.sv
// ----------------------------------------------------------------------------
// sc2a channel interfaces
// Valid/ready channels for scancode bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface sc2a_scan_if;
  logic                           valid;
  logic                           ready;
  logic [sc2a_pkg::SCAN_W-1:0]    scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface sc2a_result_if;
  logic                           valid;
  logic                           ready;
  logic [sc2a_pkg::KIND_W-1:0]    result_kind;
  logic [sc2a_pkg::CODE_W-1:0]    char_code;

  modport source (output valid, output result_kind, output char_code, input ready);
  modport sink   (input valid, input result_kind, input char_code, output ready);
endinterface

### rtl/core/sc2a_decode.sv
// ----------------------------------------------------------------------------
// sc2a_decode
// One-byte decode step: result for the byte and the next modifier flags.
// ----------------------------------------------------------------------------
module sc2a_decode (
  input  logic [sc2a_pkg::SCAN_W-1:0] scan_byte_i,
  input  sc2a_pkg::flags_t            flags_i,
  input  logic [sc2a_pkg::CODE_W-1:0] arrow_up_i,
  input  logic [sc2a_pkg::CODE_W-1:0] arrow_down_i,
  output sc2a_pkg::flags_t            flags_o,
  output sc2a_pkg::result_t           result_o
);

  logic                          handled;
  logic [sc2a_pkg::CODE_W-1:0]   key_char;
  logic [sc2a_pkg::KEY_IDX_W-1:0] key_idx;

  assign key_idx  = scan_byte_i[sc2a_pkg::KEY_IDX_W-1:0];
  assign key_char = flags_i.shift ? sc2a_pkg::SHIFT_MAP[key_idx]
                                  : sc2a_pkg::PLAIN_MAP[key_idx];

  always_comb begin
    flags_o  = flags_i;
    result_o = '{kind: sc2a_pkg::KIND_NONE, code: '0};
    handled  = 1'b0;

    if (scan_byte_i == sc2a_pkg::SC_EXT_PREFIX) begin
      flags_o.ext = 1'b1;
      handled     = 1'b1;
    end else if (flags_i.ext) begin
      flags_o.ext = 1'b0;
      // extended releases are dropped; unknown extended presses fall through
      if (scan_byte_i[sc2a_pkg::SCAN_W-1]) begin
        handled = 1'b1;
      end else begin
        case (scan_byte_i)
          sc2a_pkg::SC_PGUP: begin
            result_o.kind = sc2a_pkg::KIND_PGUP;
            handled       = 1'b1;
          end
          sc2a_pkg::SC_PGDN: begin
            result_o.kind = sc2a_pkg::KIND_PGDN;
            handled       = 1'b1;
          end
          sc2a_pkg::SC_UP: begin
            result_o = '{kind: sc2a_pkg::KIND_UP, code: arrow_up_i};
            handled  = 1'b1;
          end
          sc2a_pkg::SC_DOWN: begin
            result_o = '{kind: sc2a_pkg::KIND_DOWN, code: arrow_down_i};
            handled  = 1'b1;
          end
          default: handled = 1'b0;
        endcase
      end
    end

    if (!handled) begin
      case (scan_byte_i) inside
        sc2a_pkg::SC_LSHIFT_MK, sc2a_pkg::SC_RSHIFT_MK:   flags_o.shift = 1'b1;
        sc2a_pkg::SC_LSHIFT_BRK, sc2a_pkg::SC_RSHIFT_BRK: flags_o.shift = 1'b0;
        sc2a_pkg::SC_CTRL_MK:                             flags_o.ctrl  = 1'b1;
        sc2a_pkg::SC_CTRL_BRK:                            flags_o.ctrl  = 1'b0;
        default: begin
          if (!scan_byte_i[sc2a_pkg::SCAN_W-1] &&
              (scan_byte_i < sc2a_pkg::SCAN_W'(sc2a_pkg::KEYMAP_LEN)) &&
              (key_char != '0)) begin
            result_o.kind = sc2a_pkg::KIND_CHAR;
            result_o.code = key_char;
            // ctrl folds letters to 1..26
            if (flags_i.ctrl && (key_char inside {[8'h61:8'h7A], [8'h41:8'h5A]})) begin
              result_o.code = key_char & sc2a_pkg::CTRL_MASK;
            end
          end
        end
      endcase
    end
  end

endmodule

### rtl/core/scancode_set1_to_ascii_core.sv
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_core
// Scancode set 1 byte stream to characters, arrow and page events.
// ----------------------------------------------------------------------------
//
//  channel     dir  payload                     transfer
//  ----------  ---  --------------------------  -------------------
//  scan_if     in   scan_byte[7:0]              valid & ready
//  result_if   out  result_kind[2:0], char_code  valid & ready
//  cfg         in   cfg_idx_i, cfg_wdata_i      cfg_we_i (no ready)
//
//  A byte is held in the input register, then the table decode loads the
//  result register and raises result valid; the input transfer and the
//  result transfer are separated by both registers. Throughput is one byte
//  per cycle while the result port does not stall; the decode stage moves
//  whenever the result register is empty or is being drained in the same cycle.
//  Reset clears valids and modifier flags and sets the arrow codes (128 / 129).
//  A stalled result port backs up into the input register, then scan_if.
//
module scancode_set1_to_ascii_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sc2a_scan_if.sink                          scan_if,
  sc2a_result_if.source                      result_if,
  input  logic                               cfg_we_i,
  input  logic [sc2a_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sc2a_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  `include "scancode_set1_to_ascii_core_assert.svh"

  // input stage
  logic                          in_vld_q;
  logic [sc2a_pkg::SCAN_W-1:0]   in_byte_q;
  // result stage
  logic                          out_vld_q;
  sc2a_pkg::result_t             out_res_q;
  sc2a_pkg::result_t             dec_res;
  // modifier state, advanced only when a byte moves into the result stage
  sc2a_pkg::flags_t              flags_q;
  sc2a_pkg::flags_t              flags_d;
  // configuration
  logic [sc2a_pkg::CODE_W-1:0]   arrow_up_q;
  logic [sc2a_pkg::CODE_W-1:0]   arrow_down_q;

  logic advance;
  logic in_xfer;
  logic out_xfer;

  assign out_xfer      = out_vld_q & result_if.ready;
  assign advance       = in_vld_q & (~out_vld_q | result_if.ready);
  assign scan_if.ready = ~in_vld_q | advance;
  assign in_xfer       = scan_if.valid & scan_if.ready;

  sc2a_decode u_decode (
    .scan_byte_i  (in_byte_q),
    .flags_i      (flags_q),
    .arrow_up_i   (arrow_up_q),
    .arrow_down_i (arrow_down_q),
    .flags_o      (flags_d),
    .result_o     (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      flags_q   <= '0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        flags_q   <= flags_d;
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= scan_if.scan_byte;
    end
    if (advance) begin
      out_res_q <= dec_res;
    end
  end

  // config writes must land only while idle (no hazard with the decode stage); the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrow_up_q   <= sc2a_pkg::ARROW_UP_RST;
      arrow_down_q <= sc2a_pkg::ARROW_DOWN_RST;
    end else if (cfg_we_i) begin
      case (sc2a_pkg::cfg_idx_e'(cfg_idx_i))
        sc2a_pkg::CFG_ARROW_UP:   arrow_up_q   <= cfg_wdata_i;
        sc2a_pkg::CFG_ARROW_DOWN: arrow_down_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign result_if.valid       = out_vld_q;
  assign result_if.result_kind = out_res_q.kind;
  assign result_if.char_code   = out_res_q.code;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `SC2A_ASSERT_NEVER(a_code_zero_no_char,
    out_vld_q && (out_res_q.code != '0) &&
    ((out_res_q.kind == sc2a_pkg::KIND_NONE) || (out_res_q.kind == sc2a_pkg::KIND_PGUP) ||
     (out_res_q.kind == sc2a_pkg::KIND_PGDN)))
  `SC2A_ASSERT(a_prefix_sets_ext,
    (advance && (in_byte_q == sc2a_pkg::SC_EXT_PREFIX)) |=> flags_q.ext)
  `SC2A_ASSERT(a_ext_consumed,
    (advance && flags_q.ext && (in_byte_q != sc2a_pkg::SC_EXT_PREFIX)) |=> !flags_q.ext)
  `SC2A_ASSERT(a_break_gives_none,
    (advance && in_byte_q[sc2a_pkg::SCAN_W-1]) |=> (out_res_q.kind == sc2a_pkg::KIND_NONE))

endmodule
